### rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous frame allocator package
// Shared sizes, status codes, request and result codes, register indexes.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int Frames  = 1024;
  localparam int FrameW  = $clog2(Frames);
  localparam int EndW    = FrameW + 1;
  localparam int CntW    = FrameW + 1;
  localparam int RunW    = 11;
  localparam int ActW    = 2;
  localparam int OutW    = 2;
  localparam int FieldW  = 10;
  localparam int FirstW  = 10;
  localparam int LimitW  = 11;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 11;

  localparam logic [1:0] StFree  = 2'd0;
  localparam logic [1:0] StClean = 2'd1;
  localparam logic [1:0] StDirty = 2'd2;
  localparam logic [1:0] StFixed = 2'd3;

  localparam logic [ActW-1:0] ActKernel = 2'd0;
  localparam logic [ActW-1:0] ActUser   = 2'd1;
  localparam logic [ActW-1:0] ActFree   = 2'd2;
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  localparam logic [OutW-1:0] OutGranted = 2'd0;
  localparam logic [OutW-1:0] OutNoSpace = 2'd1;
  localparam logic [OutW-1:0] OutFreed   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgFirst = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit = 1'd1;

endpackage

### rtl/contiguous_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// Contiguous frame allocator core
// First-fit allocator of page frame runs with a status and run length table.
// ----------------------------------------------------------------------------
// A request enters on the in channel (valid/stall) and carries an action, a
// page count and a frame to free. Each request gives one result on the out
// channel: an outcome and a start frame. The two table registers are written
// through the configuration port; the user must write them only while no
// request is in flight, as the block itself does not enforce it. The frame
// status and run length tables sit in two synchronous memories. A kernel or
// user allocation scans one frame per cycle from the first allocatable
// frame, then writes one frame per cycle to mark the run. A free request
// reads the run length, then clears one frame per cycle. Requests are
// processed one at a time; the next request is taken once the result sits
// in the output register. After reset the block sweeps both memories to
// zero, one entry per cycle, and holds in_stall_o high until the sweep is
// done. When the receiver stalls, the result is held in the output
// register, and a finished later result waits until that register is taken.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cfa_pkg::ActW-1:0]   action_i,
  input  logic [10:0]                page_count_i,
  input  logic [cfa_pkg::FieldW-1:0] free_frame_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cfa_pkg::OutW-1:0]   outcome_o,
  output logic [cfa_pkg::FieldW-1:0] start_frame_o,
  input  logic                       cfg_we_i,
  input  logic [cfa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cfa_pkg::CfgW-1:0]   cfg_data_i
);
  import cfa_pkg::*;

  localparam logic [2:0] StateClear   = 3'd0;
  localparam logic [2:0] StateIdle    = 3'd1;
  localparam logic [2:0] StateScan    = 3'd2;
  localparam logic [2:0] StateMark    = 3'd3;
  localparam logic [2:0] StateFreeRd  = 3'd4;
  localparam logic [2:0] StateFreeClr = 3'd5;
  localparam logic [2:0] StateResp    = 3'd6;

  logic [1:0]        st_mem [Frames];
  logic [RunW-1:0]   rl_mem [Frames];
  logic [1:0]        st_rd_q;
  logic [RunW-1:0]   rl_rd_q;

  logic [2:0]        state_q, state_d;
  logic [FrameW-1:0] cur_q, cur_d;
  logic [FrameW-1:0] start_q, start_d;
  logic [FrameW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [RunW-1:0]   need_q, need_d;
  logic [RunW-1:0]   remain_q, remain_d;
  logic              user_q, user_d;
  logic [OutW-1:0]   res_outcome_q, res_outcome_d;
  logic [FieldW-1:0] res_start_q, res_start_d;
  logic [FirstW-1:0] first_q;
  logic [LimitW-1:0] limit_q;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_outcome_q;
  logic [FieldW-1:0] out_start_q;
  logic              out_load;

  logic [FrameW-1:0] rd_addr;
  logic              st_we, rl_we;
  logic [FrameW-1:0] st_wa, rl_wa;
  logic [1:0]        st_wd;
  logic [RunW-1:0]   rl_wd;

  logic [EndW-1:0]   scan_end;
  logic [EndW-1:0]   next_idx;
  logic [CntW:0]     cnt_inc;
  logic              usable;
  logic              hit;
  logic [FrameW-1:0] run_start;
  logic              first_ok;

  assign scan_end  = (32'(limit_q) > Frames) ? EndW'(Frames) : EndW'(limit_q);
  assign next_idx  = {1'b0, cur_q} + EndW'(1);
  assign cnt_inc   = {1'b0, count_q} + (CntW + 1)'(1);
  assign usable    = (st_rd_q == StFree) || (st_rd_q == StClean);
  assign hit       = usable && (32'(cnt_inc) >= 32'(need_q));
  assign run_start = (count_q == '0) ? cur_q : start_q;
  assign first_ok  = 32'(first_q) < 32'(scan_end);

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    start_d       = start_q;
    wr_ptr_d      = wr_ptr_q;
    count_d       = count_q;
    need_d        = need_q;
    remain_d      = remain_q;
    user_d        = user_q;
    res_outcome_d = res_outcome_q;
    res_start_d   = res_start_q;
    out_load      = 1'b0;
    st_we         = 1'b0;
    rl_we         = 1'b0;
    st_wa         = wr_ptr_q;
    rl_wa         = wr_ptr_q;
    st_wd         = StFree;
    rl_wd         = '0;
    rd_addr       = next_idx[FrameW-1:0];

    unique case (state_q)
      StateClear: begin
        st_we = 1'b1;
        rl_we = 1'b1;
        if (wr_ptr_q == FrameW'(Frames - 1)) begin
          state_d = StateIdle;
        end else begin
          wr_ptr_d = wr_ptr_q + FrameW'(1);
        end
      end
      StateIdle: begin
        rd_addr = (action_i == ActFree) ? FrameW'(free_frame_i) : FrameW'(first_q);
        if (in_valid_i) begin
          res_outcome_d = OutNoSpace;
          res_start_d   = '0;
          cur_d         = FrameW'(first_q);
          count_d       = '0;
          unique case (action_i) inside
            ActKernel, ActUser: begin
              user_d = (action_i == ActUser);
              if (action_i == ActUser || page_count_i == '0) begin
                need_d = RunW'(1);
              end else begin
                need_d = RunW'(page_count_i);
              end
              state_d = first_ok ? StateScan : StateResp;
            end
            ActFree: begin
              res_outcome_d = OutFreed;
              wr_ptr_d      = FrameW'(free_frame_i);
              state_d       = (32'(free_frame_i) < Frames) ? StateFreeRd : StateResp;
            end
            default: begin
              state_d = StateResp;
            end
          endcase
        end
      end
      StateScan: begin
        if (usable) begin
          count_d = CntW'(cnt_inc);
          start_d = run_start;
        end else begin
          count_d = '0;
        end
        if (hit) begin
          wr_ptr_d = run_start;
          remain_d = need_q;
          state_d  = StateMark;
        end else if (next_idx >= scan_end) begin
          state_d = StateResp;
        end else begin
          cur_d = next_idx[FrameW-1:0];
        end
      end
      StateMark: begin
        st_we = 1'b1;
        st_wd = user_q ? StDirty : StFixed;
        rl_we = !user_q && (wr_ptr_q == start_q);
        rl_wd = need_q;
        if (remain_q == RunW'(1)) begin
          res_outcome_d = OutGranted;
          res_start_d   = FieldW'(start_q);
          state_d       = StateResp;
        end else begin
          remain_d = remain_q - RunW'(1);
          wr_ptr_d = wr_ptr_q + FrameW'(1);
        end
      end
      StateFreeRd: begin
        remain_d = rl_rd_q;
        state_d  = (rl_rd_q == '0) ? StateResp : StateFreeClr;
      end
      StateFreeClr: begin
        st_we = 1'b1;
        rl_we = 1'b1;
        if (remain_q == RunW'(1) || wr_ptr_q == FrameW'(Frames - 1)) begin
          state_d = StateResp;
        end else begin
          remain_d = remain_q - RunW'(1);
          wr_ptr_d = wr_ptr_q + FrameW'(1);
        end
      end
      StateResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_rd_q <= st_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_wa] <= rl_wd;
    end
    rl_rd_q <= rl_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      cur_q       <= '0;
      start_q     <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      need_q      <= '0;
      remain_q    <= '0;
      user_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      start_q     <= start_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      need_q      <= need_d;
      remain_q    <= remain_d;
      user_q      <= user_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      limit_q <= LimitW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFirst: first_q <= cfg_data_i[FirstW-1:0];
        CfgLimit: limit_q <= cfg_data_i[LimitW-1:0];
        default:  first_q <= first_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_outcome_q <= res_outcome_d;
    res_start_q   <= res_start_d;
    if (out_load) begin
      out_outcome_q <= res_outcome_q;
      out_start_q   <= res_start_q;
    end
  end

  assign in_stall_o    = (state_q != StateIdle);
  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_outcome_q;
  assign start_frame_o = out_start_q;

endmodule

### rtl/cfa_checker.sv
// ----------------------------------------------------------------------------
// Contiguous frame allocator checker
// Port-level assertions on request and result behavior, bound to the core.
// ----------------------------------------------------------------------------
module cfa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [cfa_pkg::OutW-1:0]   outcome_o,
  input logic [cfa_pkg::FieldW-1:0] start_frame_o
);
  import cfa_pkg::*;

  // A held result keeps its value while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o)
      && $stable(start_frame_o))
    else $error("stalled result changed");

  // Only the three defined outcomes are ever reported.
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OutGranted || outcome_o == OutNoSpace
      || outcome_o == OutFreed))
    else $error("undefined outcome code");

  // Failures and frees report frame zero.
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OutGranted |-> start_frame_o == '0)
    else $error("nonzero start frame without a grant");

  // An accepted request keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .outcome_o     (outcome_o),
  .start_frame_o (start_frame_o)
);
